// ===== rtl/vslg_pkg.sv =====
// ----------------------------------------------------------------------------
// vslg_pkg
// Shared types and constants of the video sync level generator.
// ----------------------------------------------------------------------------
package vslg_pkg;

	localparam int LEN_W = 12;
	localparam int CNT_W = 10;
	localparam int LVL_W = 7;
	localparam int POS_W = 25;
	localparam int PRD_W = LEN_W + CNT_W;
	localparam int SMP_W = LEN_W + 1;

	localparam logic [LEN_W-1:0] ROW_LENGTH_RST = LEN_W'(1280);
	localparam logic [CNT_W-1:0] ROW_COUNT_RST  = CNT_W'(625);

	localparam logic [LVL_W-1:0] LEVEL_BLACK = LVL_W'(80);
	localparam logic [LVL_W-1:0] LEVEL_BLANK = LVL_W'(85);
	localparam logic [LVL_W-1:0] LEVEL_SYNC  = LVL_W'(100);

	// field one blanking ends at half of this line, field two runs past the
	// half frame by this many lines
	localparam int F1_END_LINES = 23;
	localparam int F2_END_LINES = 24;

	// line blanking 120/640 = 3/16, sync offset 15/640 = 3/128,
	// sync length 47/640 = (47/128)/5
	localparam int LB_MUL     = 3;
	localparam int LB_SHIFT   = 4;
	localparam int SOFF_MUL   = 3;
	localparam int SOFF_SHIFT = 7;
	localparam int SLEN_MUL   = 47;
	localparam int SLEN_SHIFT = 7;
	localparam int DIV5_MUL   = 13108;
	localparam int DIV5_SHIFT = 16;

	typedef logic signed [POS_W-1:0] pos_t;

	typedef enum logic {
		REG_ROW_LENGTH = 1'b0,
		REG_ROW_COUNT  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		pos_t             f1_lo;
		pos_t             f1_hi;
		pos_t             f2_lo;
		pos_t             f2_hi;
		pos_t             vs1_hi;
		pos_t             vs2_lo;
		pos_t             vs2_hi;
		logic [SMP_W-1:0] ln_blank;
		logic [SMP_W-1:0] ln_sync_lo;
		logic [SMP_W-1:0] ln_sync_hi;
	} bounds_t;

endpackage

// ===== rtl/vslg_bounds.sv =====
// ----------------------------------------------------------------------------
// vslg_bounds
// Region boundaries derived from the line length and line count, two stages.
// ----------------------------------------------------------------------------
module vslg_bounds
	import vslg_pkg::*;
(
	input  logic             clk,
	input  logic [LEN_W-1:0] row_length,
	input  logic [CNT_W-1:0] row_count,
	output bounds_t          bnd
);

	pos_t l_s;
	pos_t r_s;
	pos_t hr_s;

	pos_t             fe_a;
	pos_t             f1e_a;
	pos_t             f2lo_a;
	pos_t             f2hi_a;
	pos_t             vs2_a;
	pos_t             half_a;
	pos_t             fsync_a;
	logic [SMP_W-1:0] bbeg_a;
	logic [SMP_W-1:0] soff_a;
	logic [10:0]      y_a;

	logic [14:0] l3;
	logic [17:0] l47;
	logic [24:0] slen_prod;
	logic [SMP_W-1:0] slen;

	assign l_s  = pos_t'({1'b0, row_length});
	assign r_s  = pos_t'({1'b0, row_count});
	assign hr_s = pos_t'({1'b0, row_count[CNT_W-1:1]});
	assign l3   = 15'(LB_MUL) * 15'(row_length);
	assign l47  = 18'(SLEN_MUL) * 18'(row_length);

	always_ff @(posedge clk) begin
		fe_a    <= (r_s - pos_t'(2)) * l_s;
		f1e_a   <= pos_t'(F1_END_LINES) * l_s;
		f2lo_a  <= (hr_s - pos_t'(1)) * l_s;
		f2hi_a  <= (hr_s + pos_t'(F2_END_LINES)) * l_s;
		vs2_a   <= (hr_s + pos_t'(1)) * l_s;
		half_a  <= l_s >>> 1;
		fsync_a <= (l_s * pos_t'(5)) >>> 1;
		bbeg_a  <= SMP_W'(row_length) - SMP_W'(l3 >> LB_SHIFT);
		soff_a  <= SMP_W'((15'(SOFF_MUL) * 15'(row_length)) >> SOFF_SHIFT);
		y_a     <= 11'(l47 >> SLEN_SHIFT);
	end

	assign slen_prod = 25'(y_a) * 25'(DIV5_MUL);
	assign slen      = SMP_W'(slen_prod >> DIV5_SHIFT);

	always_ff @(posedge clk) begin
		bnd.f1_lo      <= fe_a + half_a;
		bnd.f1_hi      <= f1e_a + half_a;
		bnd.f2_lo      <= f2lo_a;
		bnd.f2_hi      <= f2hi_a;
		bnd.vs1_hi     <= fsync_a;
		bnd.vs2_lo     <= vs2_a + half_a;
		bnd.vs2_hi     <= vs2_a + half_a + fsync_a;
		bnd.ln_blank   <= bbeg_a;
		bnd.ln_sync_lo <= bbeg_a + soff_a;
		bnd.ln_sync_hi <= bbeg_a + soff_a + slen;
	end

endmodule

// ===== rtl/video_sync_level_generator.sv =====
// ----------------------------------------------------------------------------
// video_sync_level_generator
// Signal level stream of a blank interlaced frame with line and field sync.
// ----------------------------------------------------------------------------
// One output word leaves per accepted transaction, one transaction per clock
// when the output side keeps up; a result passes the first stage, the second
// stage and the output register before it is presented. The line and sample
// counters step and wrap with each accepted transaction. Bit 0 of the input
// data restarts the frame before that sample. Line length and line count are
// to be written by the user over the register port only while the stream is
// quiet, which the block does not enforce; region boundaries follow a write.
module video_sync_level_generator
	import vslg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [0] frame_restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [6:0] level, [16:7] line_number, [28:17] line_position
	output logic        m_axis_tuser,  // [0] frame_start
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [LEN_W-1:0] row_length_q;
	logic [CNT_W-1:0] row_count_q;
	logic [LEN_W-1:0] smp_q;
	logic [CNT_W-1:0] line_q;

	logic v_s1;
	logic v_s2;
	logic out_valid_q;
	logic rdy_out;
	logic rdy_s2;
	logic in_acc;
	logic cfg_wr;

	logic [LEN_W-1:0] cur_smp;
	logic [CNT_W-1:0] cur_line;
	logic [SMP_W-1:0] nxt_smp;
	logic [CNT_W:0]   nxt_line;

	logic [LEN_W-1:0] smp_s1;
	logic [CNT_W-1:0] line_s1;
	logic             fs_s1;
	logic [LEN_W-1:0] smp_s2;
	logic [CNT_W-1:0] line_s2;
	logic             fs_s2;
	logic [PRD_W-1:0] prod_s2;

	logic [LVL_W-1:0] lvl_q;
	logic [LEN_W-1:0] pos_q;
	logic [CNT_W-1:0] lnum_q;
	logic             fs_q;

	bounds_t          bnd;
	pos_t             p;
	logic [SMP_W-1:0] s13;
	logic [LVL_W-1:0] lvl;

	vslg_bounds u_bounds (
		.clk        (clk),
		.row_length (row_length_q),
		.row_count  (row_count_q),
		.bnd        (bnd)
	);

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_ROW_LENGTH: prdata = 32'(row_length_q);
			REG_ROW_COUNT:  prdata = 32'(row_count_q);
			default:        prdata = '0;
		endcase
	end

	assign rdy_out       = ~out_valid_q | m_axis_tready;
	assign rdy_s2        = ~v_s2 | rdy_out;
	assign s_axis_tready = ~v_s1 | rdy_s2;
	assign in_acc        = s_axis_tvalid & s_axis_tready;

	assign cur_smp  = s_axis_tdata[0] ? '0 : smp_q;
	assign cur_line = s_axis_tdata[0] ? '0 : line_q;
	assign nxt_smp  = SMP_W'(cur_smp) + SMP_W'(1);
	assign nxt_line = (CNT_W+1)'(cur_line) + (CNT_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RST;
			row_count_q  <= ROW_COUNT_RST;
			smp_q        <= '0;
			line_q       <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (reg_idx_t'(paddr[2]))
					REG_ROW_LENGTH: row_length_q <= pwdata[LEN_W-1:0];
					REG_ROW_COUNT:  row_count_q  <= pwdata[CNT_W-1:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				if (nxt_smp >= SMP_W'(row_length_q)) begin
					smp_q <= '0;
					if (nxt_line >= (CNT_W+1)'(row_count_q)) begin
						line_q <= '0;
					end else begin
						line_q <= nxt_line[CNT_W-1:0];
					end
				end else begin
					smp_q  <= nxt_smp[LEN_W-1:0];
					line_q <= cur_line;
				end
			end
			if (s_axis_tready) begin
				v_s1 <= s_axis_tvalid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_s1  <= cur_smp;
			line_s1 <= cur_line;
			fs_s1   <= (cur_smp == '0) && (cur_line == '0);
		end
		if (rdy_s2 && v_s1) begin
			smp_s2  <= smp_s1;
			line_s2 <= line_s1;
			fs_s2   <= fs_s1;
			prod_s2 <= PRD_W'(line_s1) * PRD_W'(row_length_q);
		end
		if (rdy_out && v_s2) begin
			lvl_q  <= lvl;
			pos_q  <= smp_s2;
			lnum_q <= line_s2;
			fs_q   <= fs_s2;
		end
	end

	assign p   = pos_t'({1'b0, prod_s2}) + pos_t'({1'b0, smp_s2});
	assign s13 = SMP_W'(smp_s2);

	always_comb begin
		lvl = LEVEL_BLACK;
		if (p >= bnd.f1_lo || p < bnd.f1_hi) begin
			lvl = LEVEL_BLANK;
		end
		if (p >= bnd.f2_lo && p < bnd.f2_hi) begin
			lvl = LEVEL_BLANK;
		end
		if (p < bnd.vs1_hi || (p >= bnd.vs2_lo && p < bnd.vs2_hi)) begin
			lvl = LEVEL_SYNC;
		end
		if (s13 >= bnd.ln_blank) begin
			lvl = LEVEL_BLANK;
		end
		if (s13 >= bnd.ln_sync_lo && s13 < bnd.ln_sync_hi) begin
			lvl = LEVEL_SYNC;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = fs_q;
	assign m_axis_tdata  = {3'b000, pos_q, lnum_q, lvl_q};

`ifndef NO_ASSERTIONS
	a_restart_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tdata[0]) |=> (v_s1 && fs_s1 && smp_s1 == '0 && line_s1 == '0))
		else $error("restart did not load frame origin");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled with empty output register");

	a_level_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (lvl_q == LEVEL_BLACK || lvl_q == LEVEL_BLANK || lvl_q == LEVEL_SYNC))
		else $error("level outside black, blanking and sync codes");
`endif

endmodule

// ===== tb/video_sync_level_generator_tb.sv =====
// ----------------------------------------------------------------------------
// video_sync_level_generator_tb
// Checks the sync level stream of the generator against a cycle-free model.
// Line length and line count are programmed over the register port between
// phases, from the extremes down to tiny frames that wrap many times. Each
// sample transaction is predicted from the model's own position counters and
// compared field by field with the output stream, under random input bursts,
// output stalls and frame restarts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module video_sync_level_generator_tb
	import vslg_pkg::*;
();

	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_TAIL  = 8;

	typedef struct {
		logic [LVL_W-1:0] level;
		logic             frame_start;
		logic [CNT_W-1:0] line_number;
		logic [LEN_W-1:0] line_position;
	} video_sample_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;  // [0] frame_restart
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;          // [6:0] level, [16:7] line_number, [28:17] line_position
	logic        m_axis_tuser;          // [0] frame_start
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [2:0]  paddr         = 3'd0;
	logic [31:0] pwdata        = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// model state
	logic [LEN_W-1:0] geom_len  = ROW_LENGTH_RST;
	logic [CNT_W-1:0] geom_cnt  = ROW_COUNT_RST;
	logic [LEN_W-1:0] pred_samp = '0;
	logic [CNT_W-1:0] pred_line = '0;

	video_sample_t expected_samples[$];

	int mismatch_count = 0;
	int samples_sent   = 0;
	int samples_seen   = 0;
	int restarts_sent  = 0;
	int geometries     = 0;
	int idle_cycles    = 0;

	int tx_burst_left  = 0;
	int tx_gap_max     = 0;
	bit rx_full_rate   = 1'b1;
	int rx_stall_max   = 0;
	int rx_run         = 0;

	video_sync_level_generator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #1 clk = ~clk;

	function automatic logic [LVL_W-1:0] level_for(input logic [CNT_W-1:0] ln,
			input logic [LEN_W-1:0] sm);
		longint L, R, s, p, half, fsync, f2, bbeg, soff, slen;
		logic [LVL_W-1:0] lv;
		L     = longint'(geom_len);
		R     = longint'(geom_cnt);
		s     = longint'(sm);
		p     = longint'(ln) * L + s;
		half  = L / 2;
		fsync = (L * 5) / 2;
		f2    = (R / 2 + 1) * L + half;
		bbeg  = L - (L * 120) / 640;
		soff  = (L * 15) / 640;
		slen  = (L * 47) / 640;
		lv    = LEVEL_BLACK;
		if (p >= (R - 2) * L + half || p < F1_END_LINES * L + half)
			lv = LEVEL_BLANK;
		if (p >= (R / 2 - 1) * L && p < (R / 2 + F2_END_LINES) * L)
			lv = LEVEL_BLANK;
		if (p < fsync || (p >= f2 && p < f2 + fsync))
			lv = LEVEL_SYNC;
		if (s >= bbeg)
			lv = LEVEL_BLANK;
		if (s >= bbeg + soff && s < bbeg + soff + slen)
			lv = LEVEL_SYNC;
		return lv;
	endfunction

	function automatic video_sample_t predict_sample(input logic restart);
		video_sample_t smp;
		logic [LEN_W:0]   ns;
		logic [CNT_W:0]   nl;
		if (restart) begin
			pred_samp = '0;
			pred_line = '0;
		end
		smp.level         = level_for(pred_line, pred_samp);
		smp.frame_start   = (pred_line == 0 && pred_samp == 0);
		smp.line_number   = pred_line;
		smp.line_position = pred_samp;
		// advance sample, wrap into the next line and frame
		ns = {1'b0, pred_samp} + 1'b1;
		if (ns >= {1'b0, geom_len}) begin
			ns = '0;
			nl = {1'b0, pred_line} + 1'b1;
			if (nl >= {1'b0, geom_cnt})
				nl = '0;
			pred_line = nl[CNT_W-1:0];
		end
		pred_samp = ns[LEN_W-1:0];
		return smp;
	endfunction

	task automatic send_sample(input logic restart);
		int gap;
		if (tx_burst_left == 0) begin
			tx_burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, tx_gap_max);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		tx_burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, restart};
		do @(posedge clk); while (!s_axis_tready);
		expected_samples.push_back(predict_sample(restart));
		samples_sent++;
		if (restart)
			restarts_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		tx_burst_left = 0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_ROW_LENGTH)
			geom_len = value[LEN_W-1:0];
		else
			geom_cnt = value[CNT_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_check(input reg_idx_t idx, input logic [31:0] want);
		logic [31:0] got;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t register %s: expected %0d actual %0d", $time, idx.name(), want, got);
		end
	endtask

	task automatic set_geometry(input int len, input int cnt);
		wait_drained();
		reg_write(REG_ROW_LENGTH, 32'(len));
		reg_write(REG_ROW_COUNT, 32'(cnt));
		reg_check(REG_ROW_LENGTH, {20'd0, geom_len});
		reg_check(REG_ROW_COUNT, {22'd0, geom_cnt});
		// let the region bounds settle
		repeat (4) @(posedge clk);
		geometries++;
	endtask

	task automatic test_reset_defaults();
		reg_check(REG_ROW_LENGTH, {20'd0, ROW_LENGTH_RST});
		reg_check(REG_ROW_COUNT, {22'd0, ROW_COUNT_RST});
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b0);
		send_sample(1'b1);
		send_sample(1'b0);
	endtask

	task automatic test_register_extremes();
		set_geometry(4095, 1023);
		repeat (3) send_sample(1'b0);
		set_geometry(0, 0);
		repeat (3) send_sample(1'b0);
		set_geometry(1, 1);
		repeat (2) send_sample(1'b0);
		set_geometry(2, 0);
		repeat (2) send_sample(1'b0);
		set_geometry(3, 2);
		send_sample(1'b1);
		repeat (6) send_sample(1'b0);
	endtask

	task automatic test_frame_sweep();
		int len, cnt, items;
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 5))
				4: begin
					len = $urandom_range(0, 3);
					cnt = $urandom_range(0, 4);
				end
				5: begin
					len = $urandom_range(64, 100);
					cnt = $urandom_range(50, 60);
				end
				default: begin
					len = $urandom_range(2, 16);
					cnt = $urandom_range(2, 14);
				end
			endcase
			set_geometry(len, cnt);
			tx_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 6;
			rx_full_rate = ($urandom_range(0, 2) == 0);
			rx_stall_max = $urandom_range(1, 8);
			items = $urandom_range(80, 180);
			repeat (items) send_sample($urandom_range(0, 63) == 0);
		end
	endtask

	task automatic test_shrink_registers();
		set_geometry(30, 20);
		tx_gap_max   = 4;
		rx_full_rate = 1'b0;
		send_sample(1'b1);
		repeat (199) send_sample(1'b0);
		// hold the counters and lower both limits beneath them
		set_geometry(12, 4);
		repeat (50) send_sample(1'b0);
	endtask

	task automatic test_restart_noise();
		set_geometry($urandom_range(3, 20), $urandom_range(2, 12));
		tx_gap_max   = 3;
		rx_full_rate = 1'b0;
		rx_stall_max = 5;
		repeat (100) send_sample(1'($urandom_range(0, 1)));
	endtask

	// output stall pattern
	always @(posedge clk) begin
		if (rx_full_rate)
			m_axis_tready <= 1'b1;
		else if (rx_run > 0)
			rx_run--;
		else if (m_axis_tready) begin
			m_axis_tready <= 1'b0;
			rx_run = $urandom_range(0, rx_stall_max);
		end else begin
			m_axis_tready <= 1'b1;
			rx_run = $urandom_range(1, 20);
		end
	end

	always @(posedge clk) begin : check_output
		video_sample_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			samples_seen++;
			if (expected_samples.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected transaction: expected none actual %h", $time,
					m_axis_tdata);
			end else begin
				want = expected_samples.pop_front();
				if (m_axis_tdata[6:0] !== want.level ||
						m_axis_tuser !== want.frame_start ||
						m_axis_tdata[16:7] !== want.line_number ||
						m_axis_tdata[28:17] !== want.line_position) begin
					mismatch_count++;
					$write("%0t sample: expected level %0d start %0d line %0d pos %0d",
						$time, want.level, want.frame_start, want.line_number,
						want.line_position);
					$display(" actual level %0d start %0d line %0d pos %0d",
						m_axis_tdata[6:0], m_axis_tuser, m_axis_tdata[16:7],
						m_axis_tdata[28:17]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_frame_sweep();
		test_shrink_registers();
		test_restart_noise();
		wait_drained();
		$display("Covered %0d samples (%0d restarts) over %0d line geometries, %0d checked",
			samples_sent, restarts_sent, geometries, samples_seen);
		$display("Geometries ran from empty lines and frames up to 4095 x 1023 samples");
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
